FILE: rtl/fbm_value_noise_2d_core_defines.svh
// Assertion macros shared by the fractal value noise checker.
`ifndef FBM_VALUE_NOISE_2D_CORE_DEFINES_SVH
`define FBM_VALUE_NOISE_2D_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define FBMVN_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define FBMVN_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/fbmvn_pkg.sv
// Shared types and constants of the fractal value noise core.
package fbmvn_pkg;

  // Widths of the running accumulators and of the frequency word.
  localparam int SUM_W  = 38;
  localparam int NORM_W = 21;
  localparam int FREQ_W = 48;

  // Hash mixing constants.
  localparam logic [31:0] HASH_C0 = 32'h9E3779B9;
  localparam logic [31:0] HASH_CX = 32'hC2B2AE35;
  localparam logic [31:0] HASH_CY = 32'h27D4EB2F;
  localparam logic [31:0] HASH_M1 = 32'h85EBCA77;
  localparam logic [31:0] HASH_M2 = 32'hC2B2AE3D;
  localparam int          SEED_STEP = 131;

  // Starting frequency (1.0 in Q32.16) and amplitude (0.5 in Q0.16).
  localparam logic [FREQ_W-1:0] FREQ_ONE  = 48'd65536;
  localparam logic [15:0]       AMP_START = 16'd32768;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_OCTAVES = 2'd0;
  localparam logic [1:0] REG_LACUN   = 2'd1;
  localparam logic [1:0] REG_GAIN    = 2'd2;
  localparam logic [1:0] REG_SEED    = 2'd3;

  // Register reset values.
  localparam logic [3:0]  OCTAVES_RST = 4'd4;
  localparam logic [15:0] LACUN_RST   = 16'd8192;
  localparam logic [15:0] GAIN_RST    = 16'd32768;
  localparam logic [31:0] SEED_RST    = 32'd0;

  // Configuration seen by every octave cell.
  typedef struct packed {
    logic [15:0] lacunarity;
    logic [15:0] gain;
    logic [31:0] base_seed;
  } cfg_t;

  // Item handed from one octave cell to the next.
  typedef struct packed {
    logic signed [31:0]     x;
    logic signed [31:0]     y;
    logic [FREQ_W-1:0]      freq;
    logic [15:0]            amp;
    logic signed [SUM_W-1:0] sum;
    logic [NORM_W-1:0]      norm;
  } item_t;

endpackage

FILE: rtl/fbm_value_noise_2d_core.sv
// Top level of the fractal value noise core: register port, octave chain, normalizer.
//
// Takes one point (x, y in signed Q16.16) per clock and returns one signed Q1.15
// fractal value noise sample per point, in order. Throughput is one point per
// cycle while the output side is not stalled; each point passes through a chain
// of MAX_OCTAVES octave cells of 13 stages each followed by a 17-step restoring
// divider with an entry and an output register. All octave cells are always
// traversed; cells beyond octave_count pass the running sum through unchanged.
// The whole pipeline advances when the output register is empty or being taken,
// so s_tready follows m_tready. Configuration registers sit at byte addresses 0,
// 4, 8 and 12 and must only be written while no result is outstanding.
module fbm_value_noise_2d_core #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream. s_tdata: x_coord [31:0], y_coord [63:32].
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,
  // Output stream. m_tdata: noise_value [15:0].
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int OW = $clog2(MAX_OCTAVES + 1) + 1;

  logic [3:0]              octave_count;
  fbmvn_pkg::cfg_t         cfg;
  logic                    en;
  logic [OW-1:0]           oct_n;
  logic                    cvld [0:MAX_OCTAVES];
  fbmvn_pkg::item_t        citem [0:MAX_OCTAVES];

  // Register writes complete on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count   <= fbmvn_pkg::OCTAVES_RST;
      cfg.lacunarity <= fbmvn_pkg::LACUN_RST;
      cfg.gain       <= fbmvn_pkg::GAIN_RST;
      cfg.base_seed  <= fbmvn_pkg::SEED_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        fbmvn_pkg::REG_OCTAVES: octave_count   <= pwdata[3:0];
        fbmvn_pkg::REG_LACUN:   cfg.lacunarity <= pwdata[15:0];
        fbmvn_pkg::REG_GAIN:    cfg.gain       <= pwdata[15:0];
        fbmvn_pkg::REG_SEED:    cfg.base_seed  <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (paddr[3:2])
      fbmvn_pkg::REG_OCTAVES: prdata = {28'd0, octave_count};
      fbmvn_pkg::REG_LACUN:   prdata = {16'd0, cfg.lacunarity};
      fbmvn_pkg::REG_GAIN:    prdata = {16'd0, cfg.gain};
      fbmvn_pkg::REG_SEED:    prdata = cfg.base_seed;
      default:                prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // The pipeline moves whenever the output register can take a new result.
  assign en       = m_tready || !m_tvalid;
  assign s_tready = en;

  // Octaves in use, clipped to the number of cells.
  assign oct_n = (OW'(octave_count) > OW'(MAX_OCTAVES)) ? OW'(MAX_OCTAVES)
                                                        : OW'(octave_count);

  // Item entering the first cell.
  always_comb begin
    cvld[0]       = s_tvalid && en;
    citem[0].x    = $signed(s_tdata[31:0]);
    citem[0].y    = $signed(s_tdata[63:32]);
    citem[0].freq = fbmvn_pkg::FREQ_ONE;
    citem[0].amp  = fbmvn_pkg::AMP_START;
    citem[0].sum  = '0;
    citem[0].norm = '0;
  end

  // Chain of octave cells.
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
    fbmvn_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .cfg      (cfg),
      .active   (OW'(i) < oct_n),
      .in_vld   (cvld[i]),
      .in_item  (citem[i]),
      .out_vld  (cvld[i+1]),
      .out_item (citem[i+1])
    );
  end

  // Normalization by the total amplitude.
  fbmvn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_vld    (cvld[MAX_OCTAVES]),
    .sum       (citem[MAX_OCTAVES].sum),
    .norm      (citem[MAX_OCTAVES].norm),
    .out_vld   (m_tvalid),
    .out_value (m_tdata)
  );

endmodule

FILE: rtl/fbmvn_cell.sv
// One octave cell: scales the point, hashes the lattice corners and accumulates.
module fbmvn_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  fbmvn_pkg::cfg_t     cfg,
  input  logic                active,
  input  logic                in_vld,
  input  fbmvn_pkg::item_t    in_item,
  output logic                out_vld,
  output fbmvn_pkg::item_t    out_item
);

  localparam int NST = 13;

  logic [NST-1:0] vld;
  fbmvn_pkg::item_t it_q [1:12];
  fbmvn_pkg::item_t item_s1;
  fbmvn_pkg::item_t item_out;

  logic signed [64:0] mlx, mly;
  logic [47:0]        mhx, mhy;
  logic [63:0]        fmul;
  logic [63:0]        plx, ply;
  logic [31:0]        phx, phy;
  logic [31:0]        ix, iy;
  logic [15:0]        tx, ty;
  logic [63:0]        mxp, myp;
  logic [31:0]        ttx, tty;
  logic [31:0]        mx, my;
  logic [15:0]        t2x, t2y;
  logic [17:0]        kx, ky;
  logic [31:0]        seed, base;
  logic [31:0]        hpre [4];
  logic [31:0]        hx [4];
  logic [33:0]        skx, sky;
  logic [16:0]        sx_q [4:7];
  logic [16:0]        sy_q [4:9];
  logic [63:0]        hmp [4];
  logic [31:0]        hm [4];
  logic [31:0]        hs [4];
  logic [63:0]        hnp [4];
  logic [31:0]        hn [4];
  logic [31:0]        hf [4];
  logic signed [16:0] v [4];
  logic signed [17:0] da, db;
  logic signed [35:0] pa_c, pb_c;
  logic signed [35:0] paq, pbq;
  logic signed [16:0] a0q, b0q;
  logic signed [16:0] a_q, b_q;
  logic signed [17:0] dab;
  logic signed [35:0] pab_c, pabq;
  logic signed [16:0] a2q;
  logic signed [16:0] val;
  logic signed [33:0] wv_c, wvq;
  logic [31:0]        an_c;
  logic [15:0]        anq;

  // Valid bits move one stage per enabled cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_vld};
    end
  end

  assign out_vld = vld[NST-1];

  // Stage 1: partial products of coordinate times frequency, next frequency.
  always_comb begin
    mlx = $signed(in_item.x) * $signed({1'b0, in_item.freq[31:0]});
    mly = $signed(in_item.y) * $signed({1'b0, in_item.freq[31:0]});
    mhx = $unsigned(in_item.x) * in_item.freq[47:32];
    mhy = $unsigned(in_item.y) * in_item.freq[47:32];
    fmul = in_item.freq * cfg.lacunarity;
    item_s1 = in_item;
    item_s1.freq = fmul[59:12];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plx <= mlx[63:0];
      ply <= mly[63:0];
      phx <= mhx[31:0];
      phy <= mhy[31:0];
      it_q[1] <= item_s1;
    end
  end

  // Stage 2: lattice cell (wraps modulo 2^32) and fraction.
  always_ff @(posedge clk) begin
    if (en) begin
      ix <= plx[63:32] + phx;
      iy <= ply[63:32] + phy;
      tx <= plx[31:16];
      ty <= ply[31:16];
      it_q[2] <= it_q[1];
    end
  end

  // Stage 3: hash products of the cell and squares of the fraction.
  always_comb begin
    mxp = ix * fbmvn_pkg::HASH_CX;
    myp = iy * fbmvn_pkg::HASH_CY;
    ttx = tx * tx;
    tty = ty * ty;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mx  <= mxp[31:0];
      my  <= myp[31:0];
      t2x <= ttx[31:16];
      t2y <= tty[31:16];
      kx  <= 18'h30000 - {1'b0, tx, 1'b0};
      ky  <= 18'h30000 - {1'b0, ty, 1'b0};
      it_q[3] <= it_q[2];
    end
  end

  // Stage 4: four corner hashes share one base; smoothstep weights finish.
  always_comb begin
    seed = cfg.base_seed + 32'(IDX * fbmvn_pkg::SEED_STEP);
    base = seed + fbmvn_pkg::HASH_C0 + mx + my;
    hpre[0] = base;
    hpre[1] = base + fbmvn_pkg::HASH_CX;
    hpre[2] = base + fbmvn_pkg::HASH_CY;
    hpre[3] = base + fbmvn_pkg::HASH_CX + fbmvn_pkg::HASH_CY;
    skx = t2x * kx;
    sky = t2y * ky;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        hx[k] <= hpre[k] ^ (hpre[k] >> 15);
      end
      sx_q[4] <= skx[32:16];
      sy_q[4] <= sky[32:16];
      it_q[4] <= it_q[3];
    end
  end

  // Stages 5 and 6: the two multiply rounds of the mix.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hmp[k] = hx[k] * fbmvn_pkg::HASH_M1;
      hs[k]  = hm[k] ^ (hm[k] >> 13);
      hnp[k] = hs[k] * fbmvn_pkg::HASH_M2;
      hf[k]  = hn[k] ^ (hn[k] >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        hm[k] <= hmp[k][31:0];
        hn[k] <= hnp[k][31:0];
      end
      sx_q[5] <= sx_q[4];
      sx_q[6] <= sx_q[5];
      sy_q[5] <= sy_q[4];
      sy_q[6] <= sy_q[5];
      it_q[5] <= it_q[4];
      it_q[6] <= it_q[5];
    end
  end

  // Stage 7: top 17 hash bits minus 65536, done by flipping the top bit.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        v[k] <= $signed({~hf[k][31], hf[k][30:15]});
      end
      sx_q[7] <= sx_q[6];
      sy_q[7] <= sy_q[6];
      it_q[7] <= it_q[6];
    end
  end

  // Stage 8: products of the x blends.
  always_comb begin
    da   = 18'(v[1]) - 18'(v[0]);
    db   = 18'(v[3]) - 18'(v[2]);
    pa_c = da * $signed({1'b0, sx_q[7]});
    pb_c = db * $signed({1'b0, sx_q[7]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      paq <= pa_c;
      pbq <= pb_c;
      a0q <= v[0];
      b0q <= v[2];
      sy_q[8] <= sy_q[7];
      it_q[8] <= it_q[7];
    end
  end

  // Stage 9: finish the x blends with a flooring shift.
  always_ff @(posedge clk) begin
    if (en) begin
      a_q <= 17'(18'(a0q) + 18'(paq >>> 16));
      b_q <= 17'(18'(b0q) + 18'(pbq >>> 16));
      sy_q[9] <= sy_q[8];
      it_q[9] <= it_q[8];
    end
  end

  // Stage 10: product of the y blend.
  always_comb begin
    dab   = 18'(b_q) - 18'(a_q);
    pab_c = dab * $signed({1'b0, sy_q[9]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pabq <= pab_c;
      a2q  <= a_q;
      it_q[10] <= it_q[9];
    end
  end

  // Stage 11: octave value.
  always_ff @(posedge clk) begin
    if (en) begin
      val <= 17'(18'(a2q) + 18'(pabq >>> 16));
      it_q[11] <= it_q[10];
    end
  end

  // Stage 12: weight the value and form the next amplitude.
  always_comb begin
    wv_c = $signed({1'b0, it_q[11].amp}) * val;
    an_c = it_q[11].amp * cfg.gain;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wvq <= wv_c;
      anq <= an_c[31:16];
      it_q[12] <= it_q[11];
    end
  end

  // Stage 13: accumulate when this octave is in use.
  always_comb begin
    item_out = it_q[12];
    if (active) begin
      item_out.sum  = it_q[12].sum + fbmvn_pkg::SUM_W'(wvq);
      item_out.norm = it_q[12].norm + fbmvn_pkg::NORM_W'(it_q[12].amp);
    end
    item_out.amp = anq;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_out;
    end
  end

endmodule

FILE: rtl/fbmvn_div.sv
// Pipelined normalizer: sum / (2 * norm), truncated toward zero and saturated; zero when norm is zero.
module fbmvn_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic signed [fbmvn_pkg::SUM_W-1:0]   sum,
  input  logic [fbmvn_pkg::NORM_W-1:0]         norm,
  output logic                                 out_vld,
  output logic [15:0]                          out_value
);

  localparam int SW = fbmvn_pkg::SUM_W;
  localparam int DW = fbmvn_pkg::NORM_W + 1;
  localparam int QB = 17;
  localparam int RW = SW + 1;

  logic [QB+1:0]  vld;
  logic [SW-1:0]  rem  [0:QB];
  logic [QB-1:0]  quo  [0:QB];
  logic [DW-1:0]  dvs  [0:QB];
  logic           neg  [0:QB];
  logic           zero [0:QB];
  logic [15:0]    res;

  // Valid bits of the divider stages and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QB:0], in_vld};
    end
  end

  assign out_vld = vld[QB+1];

  // Entry stage: magnitude, sign and divisor.
  always_ff @(posedge clk) begin
    if (en) begin
      neg[0]  <= sum[SW-1];
      zero[0] <= (norm == '0);
      rem[0]  <= sum[SW-1] ? SW'(-sum) : SW'(sum);
      quo[0]  <= '0;
      dvs[0]  <= {norm, 1'b0};
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int K = QB - 1 - j;
    logic [RW-1:0] dk;
    logic          ge;

    always_comb begin
      dk = RW'(dvs[j]) << K;
      ge = ({1'b0, rem[j]} >= dk);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]  <= ge ? (rem[j] - dk[SW-1:0]) : rem[j];
        quo[j+1]  <= quo[j] | (QB'(ge) << K);
        dvs[j+1]  <= dvs[j];
        neg[j+1]  <= neg[j];
        zero[j+1] <= zero[j];
      end
    end
  end

  // Sign and saturation.
  always_comb begin
    if (zero[QB]) begin
      res = '0;
    end else if (neg[QB]) begin
      res = (quo[QB] > QB'(32768)) ? 16'h8000 : 16'(-quo[QB]);
    end else begin
      res = (quo[QB] > QB'(32767)) ? 16'h7FFF : quo[QB][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= res;
    end
  end

endmodule

FILE: rtl/fbmvn_checker.sv
// Port-level checks of the fractal value noise core, bound to the top level.
`include "fbm_value_noise_2d_core_defines.svh"

module fbmvn_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [3:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // A stalled result keeps its data.
  `FBMVN_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // Input ready is high exactly when the output side can move.
  `FBMVN_ASSERT_IMP(a_ready, clk, rst, 1'b1, s_tready == (m_tready || !m_tvalid), "input ready does not follow output side")

  // Reset leaves no result pending.
  `FBMVN_ASSERT_NXT(a_rst, clk, 1'b0, rst, !m_tvalid, "result pending after reset")

  // A seed write reads back on the following cycle.
  `FBMVN_ASSERT_IMP(a_seed, clk, rst, (psel && penable && pwrite && pready && paddr[3:2] == fbmvn_pkg::REG_SEED) ##1 (paddr[3:2] == fbmvn_pkg::REG_SEED && !(psel && penable && pwrite)), prdata == $past(pwdata), "seed readback mismatch")

endmodule

bind fbm_value_noise_2d_core fbmvn_checker u_fbmvn_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for the fractal value noise core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_OCT = 8;
  localparam int LATENCY = 13 * MAX_OCT + 19;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow copy of the configuration registers.
  logic [3:0]  octaves_q;
  logic [15:0] lacun_q;
  logic [15:0] gain_q;
  logic [31:0] seed_q;

  logic [15:0] noise_expected[$];
  int          mismatches;
  int          idle_cycles;
  int          ready_hold;
  bit          stall_enable;

  fbm_value_noise_2d_core #(.MAX_OCTAVES(MAX_OCT)) dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Lattice hash of one corner.
  function automatic logic [31:0] lattice_hash(logic [31:0] cx, logic [31:0] cy,
                                               logic [31:0] seed);
    logic [31:0] h;
    h = seed + fbmvn_pkg::HASH_C0 + cx * fbmvn_pkg::HASH_CX + cy * fbmvn_pkg::HASH_CY;
    h = (h ^ (h >> 15)) * fbmvn_pkg::HASH_M1;
    h = (h ^ (h >> 13)) * fbmvn_pkg::HASH_M2;
    return h ^ (h >> 16);
  endfunction

  function automatic longint corner(logic [31:0] cx, logic [31:0] cy, logic [31:0] seed);
    return longint'({15'd0, lattice_hash(cx, cy, seed)} >> 15) - 65536;
  endfunction

  function automatic longint smooth(longint t);
    longint t2;
    t2 = (t * t) >> 16;
    return (t2 * (3 * 65536 - 2 * t)) >> 16;
  endfunction

  // Linear blend rounding the step toward minus infinity.
  function automatic longint lerp(longint a, longint b, longint s);
    longint p;
    p = (b - a) * s;
    return a + ((p >= 0) ? (p >>> 16) : -(((-p) + 65535) >>> 16));
  endfunction

  function automatic longint octave_noise(logic [63:0] px, logic [63:0] py,
                                          logic [31:0] seed);
    logic [31:0] ix, iy;
    longint sx, sy, a, b;
    ix = px[63:32];
    iy = py[63:32];
    sx = smooth(longint'(px[31:16]));
    sy = smooth(longint'(py[31:16]));
    a = lerp(corner(ix, iy, seed), corner(ix + 1, iy, seed), sx);
    b = lerp(corner(ix, iy + 1, seed), corner(ix + 1, iy + 1, seed), sx);
    return lerp(a, b, sy);
  endfunction

  // Expected noise sample for one point under the current registers.
  function automatic logic [15:0] fbm_sample(logic [31:0] xr, logic [31:0] yr);
    logic [63:0] xs, ys, freq, amp;
    longint sum, norm, res;
    int n;
    xs = {{32{xr[31]}}, xr};
    ys = {{32{yr[31]}}, yr};
    n = (octaves_q > MAX_OCT) ? MAX_OCT : octaves_q;
    freq = 64'd65536;
    amp = 64'd32768;
    sum = 0;
    norm = 0;
    res = 0;
    for (int i = 0; i < n; i++) begin
      sum += longint'(amp) * octave_noise(xs * freq, ys * freq, seed_q + i * 131);
      norm += longint'(amp);
      amp = (amp * gain_q) >> 16;
      freq = ((freq * lacun_q) >> 12) & 64'hFFFF_FFFF_FFFF;
    end
    if (norm > 0) begin
      res = sum / (2 * norm);
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
    end
    return res[15:0];
  endfunction

  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  // Send one point and record its expected sample; tvalid stays up for a follower.
  task automatic send_point(logic [31:0] x, logic [31:0] y);
    int gap;
    gap = stall_enable ? gap_length() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    noise_expected.push_back(fbm_sample(x, y));
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (noise_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      fbmvn_pkg::REG_OCTAVES: octaves_q = value[3:0];
      fbmvn_pkg::REG_LACUN:   lacun_q = value[15:0];
      fbmvn_pkg::REG_GAIN:    gain_q = value[15:0];
      default:                seed_q = value;
    endcase
  endtask

  task automatic set_config(logic [31:0] oct, logic [31:0] lac, logic [31:0] gn,
                            logic [31:0] sd);
    wait_drained();
    write_reg(fbmvn_pkg::REG_OCTAVES, oct);
    write_reg(fbmvn_pkg::REG_LACUN, lac);
    write_reg(fbmvn_pkg::REG_GAIN, gn);
    write_reg(fbmvn_pkg::REG_SEED, sd);
  endtask

  // Corner coordinates, sign extremes and fractional edges with reset registers.
  task automatic test_directed_extremes();
    logic [31:0] pts[10];
    pts = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_FFFF,
            32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'h5555_AAAA, 32'hAAAA_5555};
    for (int i = 0; i < 10; i++) send_point(pts[i], pts[9 - i]);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000);
  endtask

  // Zero octaves, octave counts above the limit, zero gain and lacunarity extremes.
  task automatic test_special_configs();
    set_config(0, 8192, 32768, 0);
    send_point(32'h1234_5678, 32'h9ABC_DEF0);
    send_point(32'hFFFF_FFFF, 32'h0);
    set_config(15, 65535, 65535, 32'hFFFF_FFFF);
    send_point(32'h0001_8000, 32'hFFFE_4000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    set_config(9, 0, 0, 32'h8000_0001);
    send_point(32'h0003_C000, 32'h0002_2000);
    set_config(8, 4096, 1, 32'h1357_9BDF);
    send_point(32'hC000_0000, 32'h4000_0000);
    set_config(1, 65535, 65535, 0);
    send_point(32'h0000_FFFF, 32'hFFFF_0001);
    send_point(32'h7FFF_0000, 32'h8000_FFFF);
  endtask

  // Random points over several random register settings.
  task automatic test_random_points();
    logic [31:0] x, y;
    for (int phase = 0; phase < 8; phase++) begin
      set_config($urandom, $urandom, $urandom, $urandom);
      if (phase == 0) write_reg(fbmvn_pkg::REG_OCTAVES, 8);
      if (phase == 1) write_reg(fbmvn_pkg::REG_OCTAVES, 0);
      for (int k = 0; k < 190; k++) begin
        x = $urandom;
        y = $urandom;
        // Mostly small coordinates so the lattice wraps slowly.
        if ($urandom_range(0, 2) != 0) begin
          x = {{12{x[19]}}, x[19:0]};
          y = {{12{y[19]}}, y[19:0]};
        end
        send_point(x, y);
      end
    end
  endtask

  // Output side: random back-pressure and result checking.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      ready_hold <= 0;
    end else begin
      if (ready_hold > 0) begin
        m_tready   <= 1'b0;
        ready_hold <= ready_hold - 1;
      end else if (stall_enable && $urandom_range(0, 3) == 0) begin
        m_tready   <= 1'b0;
        ready_hold <= gap_length();
      end else begin
        m_tready <= 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (noise_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          logic [15:0] want;
          want = noise_expected.pop_front();
          if (m_tdata !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("noise_value mismatch: expected %h actual %h", want, m_tdata);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    idle_cycles = 0;
    stall_enable = 1'b0;
    octaves_q = fbmvn_pkg::OCTAVES_RST;
    lacun_q = fbmvn_pkg::LACUN_RST;
    gain_q = fbmvn_pkg::GAIN_RST;
    seed_q = fbmvn_pkg::SEED_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    stall_enable = 1'b1;
    test_special_configs();
    test_random_points();
    wait_drained();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
+incdir+rtl
rtl/fbmvn_pkg.sv
rtl/fbmvn_cell.sv
rtl/fbmvn_div.sv
rtl/fbm_value_noise_2d_core.sv
rtl/fbmvn_checker.sv
tb/testbench.sv
